### src/pse_pkg.sv
// Package with shared types and constants of the stroke extruder.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

  // Input mode codes.
  localparam logic [1:0] ModeStart = 2'd0;
  localparam logic [1:0] ModeAdd   = 2'd1;
  localparam logic [1:0] ModeEnd   = 2'd2;

  // Configuration register indexes.
  localparam logic CfgHalfWidth  = 1'b0;
  localparam logic CfgMinSpacing = 1'b1;

  localparam logic [7:0] HalfWidthReset  = 8'd20;
  localparam logic [7:0] MinSpacingReset = 8'd10;

endpackage
`default_nettype wire

### src/pse_front.sv
// Front end: stroke state, thinning test and job classification.
`timescale 1ns / 1ps
`default_nettype none
module pse_front #(
  parameter int CoordBits = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [7:0]                  min_spacing_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  mode_i,
  input  wire logic signed [CoordBits-1:0] point_x_i,
  input  wire logic signed [CoordBits-1:0] point_y_i,
  output logic                             job_valid_o,
  input  wire logic                        job_ready_i,
  output logic signed [CoordBits-1:0]      job_vx_o,
  output logic signed [CoordBits-1:0]      job_vy_o,
  output logic signed [CoordBits:0]        job_dx_o,
  output logic signed [CoordBits:0]        job_dy_o,
  output logic                             job_last_o
);
  import pse_pkg::*;

  localparam int DW = CoordBits + 1;

  logic signed [CoordBits-1:0] bx_q, by_q, hx_q, hy_q, bx_d, by_d, hx_d, hy_d;
  logic [1:0] kc_q, kc_d;
  logic emit;
  logic signed [DW-1:0] ddx, ddy, adx, ady;
  logic [2*DW:0] dist2;
  logic [15:0] sp2;
  logic job_valid_q, job_last_q;
  logic signed [CoordBits-1:0] job_vx_q, job_vy_q;
  logic signed [DW-1:0] job_dx_q, job_dy_q;

  assign job_valid_o = job_valid_q;
  assign job_vx_o    = job_vx_q;
  assign job_vy_o    = job_vy_q;
  assign job_dx_o    = job_dx_q;
  assign job_dy_o    = job_dy_q;
  assign job_last_o  = job_last_q;

  // A single output word holds the next job; the back end queues two more.
  assign in_ready_o = !job_valid_q || job_ready_i;

  always_comb begin
    ddx = DW'(point_x_i) - DW'(hx_q);
    ddy = DW'(point_y_i) - DW'(hy_q);
    adx = ddx[DW-1] ? -ddx : ddx;
    ady = ddy[DW-1] ? -ddy : ddy;
    dist2 = (2*DW+1)'($unsigned(adx) * $unsigned(adx))
          + (2*DW+1)'($unsigned(ady) * $unsigned(ady));
    sp2 = min_spacing_i * min_spacing_i;
    bx_d = bx_q; by_d = by_q; hx_d = hx_q; hy_d = hy_q; kc_d = kc_q; emit = 1'b0;
    case (mode_i)
      ModeStart: begin
        bx_d = point_x_i; by_d = point_y_i; hx_d = point_x_i; hy_d = point_y_i;
        kc_d = 2'd1;
      end
      ModeAdd: begin
        if (kc_q != 2'd0 && dist2 > (2*DW+1)'(sp2)) begin
          emit = 1'b1;
          bx_d = hx_q; by_d = hy_q; hx_d = point_x_i; hy_d = point_y_i; kc_d = 2'd2;
        end
      end
      ModeEnd: begin
        if (kc_q != 2'd0) begin
          emit = 1'b1;
          kc_d = 2'd0;
        end
      end
      default: ;
    endcase
  end

  // Stroke state and the job word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bx_q <= '0; by_q <= '0; hx_q <= '0; hy_q <= '0; kc_q <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o && emit) job_valid_q <= 1'b1;
      else if (job_ready_i) job_valid_q <= 1'b0;
      if (in_valid_i && in_ready_o) begin
        bx_q <= bx_d; by_q <= by_d; hx_q <= hx_d; hy_q <= hy_d; kc_q <= kc_d;
        if (emit) begin
          job_vx_q <= hx_q;
          job_vy_q <= hy_q;
          job_last_q <= (mode_i == ModeEnd);
          if (mode_i == ModeEnd) begin
            job_dx_q <= DW'(hx_q) - DW'(bx_q);
            job_dy_q <= DW'(hy_q) - DW'(by_q);
          end else begin
            job_dx_q <= DW'(point_x_i) - DW'(bx_q);
            job_dy_q <= DW'(point_y_i) - DW'(by_q);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_kc_range: assert property (@(posedge clk_i) disable iff (!rst_ni) kc_q != 2'd3)
    else $error("kept count out of range");
  a_no_emit_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && kc_q == 2'd0 && mode_i != ModeStart) |=> $stable(kc_q))
    else $error("closed stroke changed");
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == ModeEnd) |=> kc_q == 2'd0)
    else $error("end did not close stroke");
`endif
endmodule
`default_nettype wire

### src/pse_back.sv
// Back end: a two-entry queue and the iterative normal offset unit.
`timescale 1ns / 1ps
`default_nettype none
module pse_back #(
  parameter int CoordBits = 16,
  parameter int FracBits  = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [7:0]                  half_width_i,
  input  wire logic                        job_valid_i,
  output logic                             job_ready_o,
  input  wire logic signed [CoordBits-1:0] job_vx_i,
  input  wire logic signed [CoordBits-1:0] job_vy_i,
  input  wire logic signed [CoordBits:0]   job_dx_i,
  input  wire logic signed [CoordBits:0]   job_dy_i,
  input  wire logic                        job_last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [CoordBits+FracBits:0] edge_a_x_o,
  output logic signed [CoordBits+FracBits:0] edge_a_y_o,
  output logic signed [CoordBits+FracBits:0] edge_b_x_o,
  output logic signed [CoordBits+FracBits:0] edge_b_y_o,
  output logic                             stroke_end_o
);
  import pse_pkg::*;

  localparam int DW  = CoordBits + 1;
  localparam int KW  = 8 + FracBits;        // width of K
  localparam int KKW = 2 * KW + 2;          // width of (2K)^2
  localparam int OW  = CoordBits + FracBits + 1;
  localparam int SW  = 2 * DW + 1;          // dx^2+dy^2
  localparam int LW  = 2 * (KW + 2) + SW;   // both sides of the compare
  localparam int CW  = $clog2(KW + 2);

  typedef enum logic [2:0] {StIdle, StSq, StRhs, StSx, StSy, StDone} st_e;

  // Queue storage: two entries, single write and single read port.
  logic signed [CoordBits-1:0] qvx [2], qvy [2];
  logic signed [DW-1:0] qdx [2], qdy [2];
  logic qlast [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  st_e st_q;
  logic signed [CoordBits-1:0] vx_q, vy_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic last_q;
  logic [DW-1:0] adx_q, ady_q;
  logic [SW-1:0] s_q;
  logic [2*DW-1:0] mx2_q, my2_q;
  logic [KKW-1:0] kk_q;
  logic [LW-1:0] rx_q, ry_q, a_q, b_q;
  logic [KW-1:0] k_q, res_q, px_q;
  logic [CW-1:0] bit_q;
  logic [LW-1:0] sw, sww, bw, a_try, b_try, lhs, rhs;
  logic [KW-1:0] trial;
  logic accept;
  logic zero_dir;
  logic pop;
  logic signed [OW-1:0] ox, oy, bxs, bys;
  logic out_valid_q, stroke_end_q;
  logic signed [OW-1:0] ea_x_q, ea_y_q, eb_x_q, eb_y_q;

  assign out_valid_o  = out_valid_q;
  assign edge_a_x_o   = ea_x_q;
  assign edge_a_y_o   = ea_y_q;
  assign edge_b_x_o   = eb_x_q;
  assign edge_b_y_o   = eb_y_q;
  assign stroke_end_o = stroke_end_q;

  assign job_ready_o = cnt_q != 2'd2;
  assign pop = st_q == StIdle && cnt_q != 2'd0 && (!out_valid_q || out_ready_i);
  assign zero_dir = dx_q == '0 && dy_q == '0;

  // Bit-serial trial: accept bit if (2r-1)^2 * s <= (2K)^2 * m^2. The left side
  // is built from a = r^2*s and b = r*s of the bits taken so far, using shifts
  // and adds only.
  always_comb begin
    trial = res_q | (KW'(1) << bit_q);
    sw    = LW'(s_q) << bit_q;
    sww   = LW'(s_q) << {bit_q, 1'b0};
    bw    = b_q << ({1'b0, bit_q} + (CW+1)'(1));
    a_try = a_q + bw + sww;
    b_try = b_q + sw;
    lhs   = (a_try << 2) - (b_try << 2) + LW'(s_q);
    rhs   = (st_q == StSx) ? rx_q : ry_q;
    accept = lhs <= rhs;
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (job_valid_i && job_ready_o) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(job_valid_i && job_ready_o) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      qvx[wp_q] <= job_vx_i; qvy[wp_q] <= job_vy_i;
      qdx[wp_q] <= job_dx_i; qdy[wp_q] <= job_dy_i; qlast[wp_q] <= job_last_i;
    end
  end

  always_comb begin
    bxs = OW'(vx_q) <<< FracBits;
    bys = OW'(vy_q) <<< FracBits;
    if (zero_dir) begin
      ox = '0; oy = OW'(k_q);
    end else begin
      ox = dy_q > 0 ? -OW'(px_q) : OW'(px_q);
      oy = dx_q[DW-1] ? -OW'(res_q) : OW'(res_q);
    end
  end

  // Offset sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; out_valid_q <= 1'b0;
    end else begin
      if (st_q == StDone) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: if (pop) begin
          vx_q <= qvx[rp_q]; vy_q <= qvy[rp_q];
          dx_q <= qdx[rp_q]; dy_q <= qdy[rp_q]; last_q <= qlast[rp_q];
          adx_q <= qdx[rp_q][DW-1] ? DW'(-qdx[rp_q]) : qdx[rp_q];
          ady_q <= qdy[rp_q][DW-1] ? DW'(-qdy[rp_q]) : qdy[rp_q];
          k_q <= KW'(half_width_i) << FracBits;
          st_q <= StSq;
        end
        StSq: begin
          s_q <= SW'(adx_q * adx_q) + SW'(ady_q * ady_q);
          mx2_q <= adx_q * adx_q;
          my2_q <= ady_q * ady_q;
          kk_q <= KKW'({k_q, 1'b0}) * KKW'({k_q, 1'b0});
          st_q <= StRhs;
        end
        // Right-hand bounds for both axes, then start the x search.
        StRhs: begin
          rx_q <= LW'(kk_q * my2_q);
          ry_q <= LW'(kk_q * mx2_q);
          res_q <= '0; a_q <= '0; b_q <= '0; bit_q <= CW'(KW - 1);
          st_q <= StSx;
        end
        StSx, StSy: begin
          if (bit_q == '0 && st_q == StSx) begin
            px_q <= accept ? trial : res_q;
            res_q <= '0; a_q <= '0; b_q <= '0; bit_q <= CW'(KW - 1);
            st_q <= StSy;
          end else begin
            if (accept) begin
              res_q <= trial; a_q <= a_try; b_q <= b_try;
            end
            if (bit_q == '0) st_q <= StDone;
            else bit_q <= bit_q - CW'(1);
          end
        end
        StDone: begin
          ea_x_q <= bxs + ox; ea_y_q <= bys + oy;
          eb_x_q <= bxs - ox; eb_y_q <= bys - oy;
          stroke_end_q <= last_q;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> st_q == StSq)
    else $error("pop did not start unit");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDone |=> out_valid_q)
    else $error("result lost");
`endif
endmodule
`default_nettype wire

### src/polyline_stroke_extruder_unit.sv
// Top level of the polyline stroke extruder.
// Use: pointer words (mode, point_x, point_y) enter on in_valid_i/in_ready_o.
// A start word opens a stroke, add words are thinned by min_spacing, and an
// end word flushes the last vertex. Each kept vertex gives one output word
// with the two strip edges and stroke_end on out_valid_o/out_ready_i.
// Configuration words (index 0 half_width, 1 min_spacing) enter on cfg_*.
// The front end classifies a word and posts a job into a two-entry
// queue. The back end computes the squared terms and bounds in the
// states StSq and StRhs, then runs a bit-serial ratio search, one bit
// per cycle for each axis, and registers the edges in StDone. The queue
// takes new jobs while the back end is busy; the back end pops the next
// job only when idle and its output word is free or taken. Words that
// give no result are taken at one per cycle while the job word is free.
// Reset clears the stroke state, the queue and the output word and loads
// the configuration defaults. When the receiver stalls, the output word
// holds, the back end waits, and the queue then fills and stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module polyline_stroke_extruder_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [COORD_BITS+FRAC_BITS:0] edge_a_x_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] edge_a_y_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] edge_b_x_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] edge_b_y_o,
  output logic      stroke_end_o
);
  import pse_pkg::*;

  logic [7:0] hw_q, ms_q;
  logic jv, jr, jl;
  logic signed [COORD_BITS-1:0] jvx, jvy;
  logic signed [COORD_BITS:0] jdx, jdy;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HalfWidthReset; ms_q <= MinSpacingReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgHalfWidth) hw_q <= cfg_data_i;
      else ms_q <= cfg_data_i;
    end
  end

  pse_front #(.CoordBits(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .min_spacing_i(ms_q),
    .in_valid_i, .in_ready_o, .mode_i, .point_x_i, .point_y_i,
    .job_valid_o(jv), .job_ready_i(jr), .job_vx_o(jvx), .job_vy_o(jvy),
    .job_dx_o(jdx), .job_dy_o(jdy), .job_last_o(jl)
  );

  pse_back #(.CoordBits(COORD_BITS), .FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .half_width_i(hw_q),
    .job_valid_i(jv), .job_ready_o(jr), .job_vx_i(jvx), .job_vy_i(jvy),
    .job_dx_i(jdx), .job_dy_i(jdy), .job_last_i(jl),
    .out_valid_o, .out_ready_i, .edge_a_x_o, .edge_a_y_o,
    .edge_b_x_o, .edge_b_y_o, .stroke_end_o
  );

`ifndef SYNTHESIS
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == CfgMinSpacing) |=> ms_q == $past(cfg_data_i))
    else $error("config write lost");
  a_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_valid_i) |=> $stable(hw_q))
    else $error("half width changed");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output dropped");
`endif
endmodule
`default_nettype wire

### tb/sv/polyline_stroke_extruder_unit_tb.sv
// Self-checking testbench for the polyline stroke extruder: directed table plus random strokes.
`timescale 1ns / 1ps
module polyline_stroke_extruder_unit_tb;
  import pse_pkg::*;

  localparam int CB = 16;
  localparam int FB = 4;
  localparam int OW = CB + FB + 1;
  localparam int SETTLE = 120;
  localparam longint LIMIT = 3000000;
  localparam logic [1:0] ModeIdle = 2'd3;

  typedef struct packed {
    logic signed [OW-1:0] ax;
    logic signed [OW-1:0] ay;
    logic signed [OW-1:0] bx;
    logic signed [OW-1:0] by;
    logic                 fin;
  } strip_pair_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 typed;
    strip_pair_t          pair;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = 8'd0;
  logic in_valid_i = 1'b0;
  logic [1:0] mode_i = ModeIdle;
  logic signed [CB-1:0] point_x_i = '0;
  logic signed [CB-1:0] point_y_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_ready_o, in_ready_o, out_valid_o, stroke_end_o;
  logic signed [OW-1:0] edge_a_x_o, edge_a_y_o, edge_b_x_o, edge_b_y_o;

  polyline_stroke_extruder_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .point_x_i, .point_y_i,
    .out_valid_o, .out_ready_i, .edge_a_x_o, .edge_a_y_o, .edge_b_x_o,
    .edge_b_y_o, .stroke_end_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the stroke state and the registers.
  logic [7:0] half_width, min_spacing;
  longint prev_x, prev_y, held_x, held_y;
  int kept_count;
  strip_pair_t pending_pairs[$];
  int mismatches = 0;
  longint cycles = 0;
  int burst_left = 0;

  // Rounded k*m/sqrt(s) by a search on the rounding boundary, ties away from zero.
  function automatic longint offset_mag(longint k, longint m, longint s);
    longint lo, hi, r, t;
    logic [127:0] lhs, rhs;
    lo = 0;
    hi = k;
    while (lo < hi) begin
      r = (lo + hi + 1) / 2;
      t = 2 * r - 1;
      lhs = 128'(t * t) * 128'(s);
      rhs = 128'((2 * k) * (2 * k)) * 128'(m * m);
      if (lhs <= rhs) lo = r;
      else hi = r - 1;
    end
    return lo;
  endfunction

  function automatic strip_pair_t make_pair(longint vx, longint vy, longint dx, longint dy,
                                            logic fin);
    strip_pair_t p;
    longint k, ox, oy, mx, my;
    k = longint'(half_width) << FB;
    if (dx == 0 && dy == 0) begin
      ox = 0;
      oy = k;
    end else begin
      mx = offset_mag(k, dy < 0 ? -dy : dy, dx * dx + dy * dy);
      my = offset_mag(k, dx < 0 ? -dx : dx, dx * dx + dy * dy);
      ox = (dy > 0) ? -mx : mx;
      oy = (dx < 0) ? -my : my;
    end
    p.ax = OW'((vx << FB) + ox);
    p.ay = OW'((vy << FB) + oy);
    p.bx = OW'((vx << FB) - ox);
    p.by = OW'((vy << FB) - oy);
    p.fin = fin;
    return p;
  endfunction

  // Advance the stroke state for one accepted word; returns 1 when a pair is due.
  function automatic logic stroke_step(logic [1:0] mode, logic signed [CB-1:0] x,
                                       logic signed [CB-1:0] y, output strip_pair_t p);
    longint px, py, ddx, ddy;
    px = x;
    py = y;
    p = '0;
    case (mode)
      ModeStart: begin
        held_x = px; held_y = py; prev_x = px; prev_y = py;
        kept_count = 1;
        return 1'b0;
      end
      ModeAdd: begin
        if (kept_count == 0) return 1'b0;
        ddx = px - held_x;
        ddy = py - held_y;
        if (ddx * ddx + ddy * ddy <= longint'(min_spacing) * longint'(min_spacing))
          return 1'b0;
        p = make_pair(held_x, held_y, px - prev_x, py - prev_y, 1'b0);
        prev_x = held_x; prev_y = held_y; held_x = px; held_y = py;
        kept_count = 2;
        return 1'b1;
      end
      ModeEnd: begin
        if (kept_count == 0) return 1'b0;
        p = make_pair(held_x, held_y, held_x - prev_x, held_y - prev_y, 1'b1);
        kept_count = 0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Receiver: the stall pattern steps through four settings, keyed to the cycle counter.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    case ((cycles >> 8) % 4)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 0);
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= ($urandom_range(0, 3) != 0);
    endcase
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Compare each accepted output word with the oldest expected pair.
  always @(posedge clk_i) begin
    strip_pair_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{edge_a_x_o, edge_a_y_o, edge_b_x_o, edge_b_y_o, stroke_end_o};
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %p", got);
      end else begin
        want = pending_pairs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic send_word(logic [1:0] mode, logic signed [CB-1:0] x,
                           logic signed [CB-1:0] y, logic typed, strip_pair_t typed_pair);
    strip_pair_t p;
    int gap;
    in_valid_i <= 1'b1;
    mode_i <= mode;
    point_x_i <= x;
    point_y_i <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (stroke_step(mode, x, y, p)) pending_pairs.push_back(typed ? typed_pair : p);
    // Sender bursts with random gaps between them.
    if (burst_left > 0) burst_left--;
    else begin
      gap = $urandom_range(0, 40);
      burst_left = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgHalfWidth) half_width = data;
    else min_spacing = data;
  endtask

  // Random strokes: mostly well-formed, some noise.
  task automatic random_phase(int words);
    int n, steps, kind;
    logic signed [CB-1:0] x, y;
    n = 0;
    while (n < words) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_word(2'($urandom_range(0, 3)), CB'($urandom), CB'($urandom), 1'b0, '0);
      end else begin
        x = ($urandom_range(0, 3) == 0) ? CB'($urandom) : CB'($urandom_range(0, 2000) - 1000);
        y = ($urandom_range(0, 3) == 0) ? CB'($urandom) : CB'($urandom_range(0, 2000) - 1000);
        send_word(ModeStart, x, y, 1'b0, '0);
        n++;
        steps = $urandom_range(0, 6);
        for (int i = 0; i < steps; i++) begin
          case ($urandom_range(0, 5))
            0: begin x = CB'($urandom); y = CB'($urandom); end
            1: begin
              x = x + CB'($urandom_range(0, 16) - 8);
              y = y + CB'($urandom_range(0, 16) - 8);
            end
            default: begin
              x = x + CB'($urandom_range(0, 600) - 300);
              y = y + CB'($urandom_range(0, 600) - 300);
            end
          endcase
          send_word(ModeAdd, x, y, 1'b0, '0);
          n++;
        end
        if ($urandom_range(0, 7) != 0) begin
          send_word(ModeEnd, CB'($urandom), CB'($urandom), 1'b0, '0);
          n++;
        end
      end
    end
  endtask

  stim_row_t rows[18];

  initial begin
    rows = '{
      '{ModeAdd,   16'sd5,      16'sd5,      1'b0, '0},
      '{ModeEnd,   16'sd0,      16'sd0,      1'b0, '0},
      '{ModeIdle,  16'sd7,      16'sd7,      1'b0, '0},
      '{ModeStart, 16'sd0,      16'sd0,      1'b0, '0},
      '{ModeEnd,   16'sd0,      16'sd0,      1'b1, '{21'sd0, 21'sd320, 21'sd0, -21'sd320, 1'b1}},
      '{ModeStart, 16'sd32767,  16'sd32767,  1'b0, '0},
      '{ModeEnd,   16'sd0,      16'sd0,      1'b1,
        '{21'sd524272, 21'sd524592, 21'sd524272, 21'sd523952, 1'b1}},
      '{ModeStart, -16'sd32768, -16'sd32768, 1'b0, '0},
      '{ModeEnd,   -16'sd1,     -16'sd1,     1'b1,
        '{-21'sd524288, -21'sd523968, -21'sd524288, -21'sd524608, 1'b1}},
      '{ModeStart, 16'sd0,      16'sd0,      1'b0, '0},
      '{ModeAdd,   16'sd10,     16'sd0,      1'b0, '0},
      '{ModeAdd,   16'sd11,     16'sd0,      1'b1, '{21'sd0, 21'sd320, 21'sd0, -21'sd320, 1'b0}},
      '{ModeAdd,   16'sd11,     -16'sd200,   1'b0, '0},
      '{ModeStart, 16'sd50,     16'sd50,     1'b0, '0},
      '{ModeAdd,   -16'sd32768, 16'sd32767,  1'b0, '0},
      '{ModeAdd,   16'sd32767,  -16'sd32768, 1'b0, '0},
      '{ModeEnd,   16'sd0,      16'sd0,      1'b0, '0},
      '{ModeAdd,   16'sd0,      16'sd0,      1'b0, '0}
    };
    half_width = HalfWidthReset;
    min_spacing = MinSpacingReset;
    prev_x = 0; prev_y = 0; held_x = 0; held_y = 0;
    kept_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset register values.
    foreach (rows[i]) send_word(rows[i].mode, rows[i].x, rows[i].y, rows[i].typed, rows[i].pair);
    drain();

    // Register settings, extremes first, each followed by random strokes.
    for (int ph = 0; ph < 6; ph++) begin
      logic [7:0] hw, ms;
      case (ph)
        0: begin hw = 8'd0;   ms = 8'd0;   end
        1: begin hw = 8'd255; ms = 8'd255; end
        2: begin hw = 8'd255; ms = 8'd0;   end
        3: begin hw = 8'd20;  ms = 8'd10;  end
        default: begin hw = 8'($urandom); ms = 8'($urandom_range(0, 40)); end
      endcase
      cfg_write(CfgHalfWidth, hw);
      cfg_write(CfgMinSpacing, ms);
      cfg_valid_i <= 1'b0;
      random_phase(85);
      drain();
    end

    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
src/pse_pkg.sv
src/pse_front.sv
src/pse_back.sv
src/polyline_stroke_extruder_unit.sv
tb/sv/polyline_stroke_extruder_unit_tb.sv
